### rtl/tgr_pkg.sv
// Shared types, constants and the 5x7 glyph table of the text glyph rasterizer.
// This package has no dependencies and is used by rtl/text_glyph_rasterizer.sv.
package tgr_pkg;

  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_COUNT = 41;
  localparam int GLYPH_BITS  = GLYPH_ROWS * GLYPH_COLS;

  // Glyph columns plus one blank column of spacing between characters.
  localparam int CELL_COLS   = GLYPH_COLS + 1;

  localparam int COORD_W     = 16;
  // Working width of coordinate sums before saturation.
  localparam int ACC_W       = COORD_W + 2;
  localparam int SIZE_W      = 8;
  localparam int COLOR_W     = 32;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int COL_W       = $clog2(GLYPH_COLS);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_X    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOT_SIZE   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR = 8'd3;

  localparam logic signed [COORD_W-1:0] START_X_RESET    = 16'sd0;
  localparam logic signed [COORD_W-1:0] START_Y_RESET    = 16'sd0;
  localparam logic [SIZE_W-1:0]         DOT_SIZE_RESET   = 8'd1;
  localparam logic [COLOR_W-1:0]        DRAW_COLOR_RESET = 32'hFFFF_FFFF;

  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_FOLD    = 8'h20;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 18'sd32767;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -18'sd32768;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       first_of_text;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] square_x;
    logic signed [COORD_W-1:0] square_y;
    logic [SIZE_W-1:0]         square_size;
    logic [COLOR_W-1:0]        square_color;
    logic                      last_square;
  } out_t;

  localparam logic [7:0] GLYPH_CODES [GLYPH_COUNT] = '{
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
    8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
    8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
    8'h3C, 8'h3E, 8'h2D, 8'h3A, 8'h2E
  };

  // One row per entry, leftmost pixel in the most significant bit.
  localparam logic [GLYPH_COLS-1:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_ROWS] = '{
    '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
    '{5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F},
    '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
    '{5'h0F, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F},
    '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
    '{5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C},
    '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
    '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
    '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
    '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
    '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
    '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11},
    '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
    '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F},
    '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
    '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
    '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
    '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
    '{5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E},
    '{5'h02, 5'h04, 5'h08, 5'h10, 5'h08, 5'h04, 5'h02},
    '{5'h08, 5'h04, 5'h02, 5'h01, 5'h02, 5'h04, 5'h08},
    '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
    '{5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00},
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h04}
  };

  // Returns the glyph as a flat pixel vector in scan order: bit 0 is the top
  // left pixel, and each row follows the one above it. Unknown codes are blank.
  function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [7:0] code);
    logic [7:0]            key;
    logic [GLYPH_BITS-1:0] bits;
    key  = code;
    bits = '0;
    if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
      key = code - CASE_FOLD;
    end
    for (int i = 0; i < GLYPH_COUNT; i++) begin
      if (GLYPH_CODES[i] == key) begin
        for (int r = 0; r < GLYPH_ROWS; r++) begin
          for (int c = 0; c < GLYPH_COLS; c++) begin
            bits[r*GLYPH_COLS + c] = GLYPH_ROM[i][r][GLYPH_COLS-1-c];
          end
        end
      end
    end
    return bits;
  endfunction

  // Clamps a working sum to the signed 16-bit coordinate range.
  function automatic logic signed [COORD_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [COORD_W-1:0] res;
    if (v > SAT_MAX) begin
      res = SAT_MAX[COORD_W-1:0];
    end else if (v < SAT_MIN) begin
      res = SAT_MIN[COORD_W-1:0];
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

### rtl/text_glyph_rasterizer.sv
// Top level of the text glyph rasterizer: request handshakes, glyph scan and
// cursor tracking. Depends on rtl/tgr_pkg.sv for types, the glyph table and helpers.

// Each input request carries one character byte. Lower-case letters are folded
// to upper case and looked up in a 5x7 glyph table holding A-Z, 0-9 and the
// characters < > - : . ; every other code is blank. The glyph is scanned one
// pixel per cycle while the output register is free, row by row from the top
// left, and every set pixel produces one output request describing a filled
// square: its saturated x and y, the square size (dot_size) and the fill color
// (draw_color). last_square marks the final square of a character. The glyph
// bits are read into the scan register when the character is accepted; the
// scan then steps over the pixels until no set pixel remains (35 at most),
// pausing while a finished square waits on out_stall. The input is stalled
// for the whole scan. Blank glyphs still pass through the scan and emit
// nothing. After every character the cursor moves right by six pixel
// sizes, saturating at the 16-bit limits; a request with first_of_text set
// reloads the cursor from start_x first. With the pixel size at zero a character
// emits nothing and the cursor is not moved on. Configuration writes are
// always taken (cfg_ready is tied high) and must only be issued while the
// block is idle; writes to unknown indexes are ignored.
module text_glyph_rasterizer (
  input  logic                                clk,
  input  logic                                rst,
  // Character requests.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tgr_pkg::in_t                        in_data,
  // Square requests.
  output logic                                out_valid,
  input  logic                                out_stall,
  output tgr_pkg::out_t                       out_data,
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tgr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tgr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Configuration registers.
  logic signed [tgr_pkg::COORD_W-1:0] start_x;
  logic signed [tgr_pkg::COORD_W-1:0] start_y;
  logic [tgr_pkg::SIZE_W-1:0]         dot_size;
  logic [tgr_pkg::COLOR_W-1:0]        draw_color;

  // Scan state.
  tgr_pkg::state_t                    state;
  tgr_pkg::state_t                    state_next;
  logic [tgr_pkg::GLYPH_BITS-1:0]     pattern;
  logic [tgr_pkg::COL_W-1:0]          col;
  logic signed [tgr_pkg::ACC_W-1:0]   x_acc;
  logic signed [tgr_pkg::ACC_W-1:0]   y_acc;
  logic signed [tgr_pkg::COORD_W-1:0] cursor;

  logic                               in_accept;
  logic                               slot_free;
  logic                               scan_step;
  logic                               scan_done;
  logic signed [tgr_pkg::COORD_W-1:0] cursor_load;
  logic [tgr_pkg::SIZE_W+2:0]         advance;
  logic signed [tgr_pkg::ACC_W-1:0]   cursor_sum;
  logic signed [tgr_pkg::ACC_W-1:0]   pixel_step;

  assign cfg_ready = 1'b1;

  // The output register is free when it is empty or its square is taken now.
  assign slot_free  = !out_valid || !out_stall;
  assign in_accept  = in_valid && !in_stall;
  // The scan ends once the pixel at hand is the last set pixel of the glyph.
  assign scan_done  = !(|pattern[tgr_pkg::GLYPH_BITS-1:1]);

  assign cursor_load = in_data.first_of_text ? start_x : cursor;
  assign pixel_step  = tgr_pkg::ACC_W'({1'b0, dot_size});
  // Six pixel sizes: four plus two, as shifts.
  assign advance     = ({3'b000, dot_size} << 2) + ({3'b000, dot_size} << 1);
  assign cursor_sum  = tgr_pkg::ACC_W'(cursor)
                     + tgr_pkg::ACC_W'({1'b0, advance});

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tgr_pkg::ST_IDLE: begin
        if (in_accept && dot_size != '0) begin
          state_next = tgr_pkg::ST_SCAN;
        end
      end
      tgr_pkg::ST_SCAN: begin
        if (slot_free && scan_done) begin
          state_next = tgr_pkg::ST_IDLE;
        end
      end
      default: state_next = tgr_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall  = 1'b1;
    scan_step = 1'b0;
    unique case (state)
      tgr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      tgr_pkg::ST_SCAN: begin
        scan_step = slot_free;
      end
      default: begin
        in_stall  = 1'b1;
        scan_step = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tgr_pkg::ST_IDLE;
      start_x    <= tgr_pkg::START_X_RESET;
      start_y    <= tgr_pkg::START_Y_RESET;
      dot_size   <= tgr_pkg::DOT_SIZE_RESET;
      draw_color <= tgr_pkg::DRAW_COLOR_RESET;
      cursor     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tgr_pkg::REG_START_X:    start_x    <= cfg_data[tgr_pkg::COORD_W-1:0];
          tgr_pkg::REG_START_Y:    start_y    <= cfg_data[tgr_pkg::COORD_W-1:0];
          tgr_pkg::REG_DOT_SIZE:   dot_size   <= cfg_data[tgr_pkg::SIZE_W-1:0];
          tgr_pkg::REG_DRAW_COLOR: draw_color <= cfg_data[tgr_pkg::COLOR_W-1:0];
          default: ;
        endcase
      end

      // The cursor is reloaded on acceptance and moved on when the scan ends.
      if (in_accept) begin
        cursor <= cursor_load;
      end else if (scan_step && scan_done) begin
        cursor <= tgr_pkg::sat16(cursor_sum);
      end

      if (scan_step && pattern[0]) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and scan datapath.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pattern <= tgr_pkg::glyph_bits(in_data.char_code);
      col     <= '0;
      x_acc   <= tgr_pkg::ACC_W'(cursor_load);
      y_acc   <= tgr_pkg::ACC_W'(start_y);
    end else if (scan_step) begin
      pattern <= pattern >> 1;
      if (col == tgr_pkg::COL_W'(tgr_pkg::GLYPH_COLS - 1)) begin
        col   <= '0;
        x_acc <= tgr_pkg::ACC_W'(cursor);
        y_acc <= y_acc + pixel_step;
      end else begin
        col   <= col + 1'b1;
        x_acc <= x_acc + pixel_step;
      end
    end

    if (scan_step && pattern[0]) begin
      out_data.square_x     <= tgr_pkg::sat16(x_acc);
      out_data.square_y     <= tgr_pkg::sat16(y_acc);
      out_data.square_size  <= dot_size;
      out_data.square_color <= draw_color;
      out_data.last_square  <= scan_done;
    end
  end

endmodule

### test/text_glyph_rasterizer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the text glyph rasterizer: a directed table followed
// by random text streams, checked against typed runs or an in-bench predictor.
// Depends on rtl/tgr_pkg.sv and rtl/text_glyph_rasterizer.sv.
module text_glyph_rasterizer_tb;

  // Cycles the block may still need after the last square of a phase has come out:
  // a blank glyph draws nothing but still passes through the scan.
  localparam int SETTLE_CYCLES = 64;
  // Length of the receiver hold-off used to back the block up into its input.
  localparam int HOLD_CYCLES   = 300;

  localparam int COORD_MAX = 32767;
  localparam int COORD_MIN = -32768;

  // Any index past the last register must be dropped by the block.
  localparam logic [tgr_pkg::CFG_IDX_W-1:0] REG_UNKNOWN = 8'hA5;

  typedef enum logic {
    ROW_CHAR,
    ROW_REG
  } row_kind_t;

  // One line of the directed table. For character rows with typed set, the
  // expected squares are a straight run of n squares starting at (x0, y0) and
  // stepping by (dx, dy); every other character row goes through the predictor.
  typedef struct packed {
    row_kind_t                      kind;
    logic [tgr_pkg::CFG_IDX_W-1:0]  idx;
    logic [tgr_pkg::CFG_DATA_W-1:0] data;
    logic [7:0]                     code;
    logic                           first;
    logic                           typed;
    int                             n;
    int                             x0;
    int                             y0;
    int                             dx;
    int                             dy;
    logic [tgr_pkg::SIZE_W-1:0]     size;
    logic [tgr_pkg::COLOR_W-1:0]    color;
  } plan_row_t;

  localparam int PLAN_ROWS = 30;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // Straight after reset: a dash at the origin, one unit squares, white.
    '{ROW_CHAR, 8'd0, 32'd0, "-", 1'b1, 1'b1, 5, 0, 3, 1, 0, 8'd1, 32'hFFFF_FFFF},
    '{ROW_CHAR, 8'd0, 32'd0, "A", 1'b0, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    '{ROW_CHAR, 8'd0, 32'd0, "q", 1'b0, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    // Codes with no glyph draw nothing, the high half of the byte range included.
    '{ROW_CHAR, 8'd0, 32'd0, " ", 1'b0, 1'b1, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    '{ROW_CHAR, 8'd0, 32'd0, 8'hFF, 1'b1, 1'b1, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    '{ROW_CHAR, 8'd0, 32'd0, 8'h80, 1'b0, 1'b1, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    '{ROW_CHAR, 8'd0, 32'd0, ".", 1'b0, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    '{ROW_REG, REG_UNKNOWN, 32'h0000_1234,
      8'd0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    // Top corner of the coordinate space with the largest squares. The upper
    // data bits of some writes carry junk that the block has to drop.
    '{ROW_REG, tgr_pkg::REG_START_X, 32'h0000_7FFF,
      8'd0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    '{ROW_REG, tgr_pkg::REG_START_Y, 32'hFFFF_7FFF,
      8'd0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    '{ROW_REG, tgr_pkg::REG_DOT_SIZE, 32'hABCD_00FF,
      8'd0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    '{ROW_REG, tgr_pkg::REG_DRAW_COLOR, 32'h0000_0000,
      8'd0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    // Every square clamps to the corner.
    '{ROW_CHAR, 8'd0, 32'd0, "-", 1'b1, 1'b1, 5, 32767, 32767, 0, 0, 8'd255, 32'h0},
    '{ROW_CHAR, 8'd0, 32'd0, "8", 1'b0, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    // Bottom corner of the coordinate space.
    '{ROW_REG, tgr_pkg::REG_START_X, 32'h0000_8000,
      8'd0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    '{ROW_REG, tgr_pkg::REG_START_Y, 32'h0000_8000,
      8'd0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    '{ROW_REG, tgr_pkg::REG_DRAW_COLOR, 32'h8142_24C3,
      8'd0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    '{ROW_CHAR, 8'd0, 32'd0, ".", 1'b1, 1'b1, 2, -32258, -31493, 0, 255, 8'd255,
      32'h8142_24C3},
    '{ROW_CHAR, 8'd0, 32'd0, "m", 1'b0, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    // Zero pixel size: nothing drawn, cursor frozen, but the reload still happens.
    '{ROW_REG, tgr_pkg::REG_DOT_SIZE, 32'h0000_0000,
      8'd0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    '{ROW_CHAR, 8'd0, 32'd0, "W", 1'b1, 1'b1, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    '{ROW_CHAR, 8'd0, 32'd0, "Z", 1'b0, 1'b1, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    '{ROW_REG, tgr_pkg::REG_DOT_SIZE, 32'h0000_0001,
      8'd0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    // The cursor must still sit on start_x from the reload above.
    '{ROW_CHAR, 8'd0, 32'd0, "-", 1'b0, 1'b1, 5, -32768, -32765, 1, 0, 8'd1,
      32'h8142_24C3},
    '{ROW_CHAR, 8'd0, 32'd0, ":", 1'b0, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    '{ROW_CHAR, 8'd0, 32'd0, "<", 1'b0, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    '{ROW_CHAR, 8'd0, 32'd0, ">", 1'b0, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    '{ROW_CHAR, 8'd0, 32'd0, "0", 1'b1, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    '{ROW_CHAR, 8'd0, 32'd0, "9", 1'b0, 1'b0, 0, 0, 0, 0, 0, 8'd0, 32'd0},
    '{ROW_CHAR, 8'd0, 32'd0, 8'h00, 1'b0, 1'b1, 0, 0, 0, 0, 0, 8'd0, 32'd0}
  };

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  tgr_pkg::in_t                   in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  tgr_pkg::out_t                  out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [tgr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tgr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and the text cursor.
  int                             start_x_r;
  int                             start_y_r;
  logic [tgr_pkg::SIZE_W-1:0]     size_r;
  logic [tgr_pkg::COLOR_W-1:0]    color_r;
  int                             cursor_r;

  // Squares predicted for accepted characters, oldest first.
  tgr_pkg::out_t                  pending_squares [$];
  int                             errors = 0;

  // Idle rates in percent, changed by the main sequence per phase.
  int                             send_idle_pct = 0;
  int                             recv_idle_pct = 0;
  // Set by the main sequence; the receiver process turns it into a hold-off.
  bit                             hold_request = 1'b0;
  int                             hold_left = 0;

  text_glyph_rasterizer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // The run is bounded far above the slowest correct run, even with every
  // character drawing 35 squares against a mostly stalled receiver.
  initial begin : watchdog
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic signed [tgr_pkg::COORD_W-1:0] clamp_coord(input int v);
    if (v > COORD_MAX) return COORD_MAX[tgr_pkg::COORD_W-1:0];
    if (v < COORD_MIN) return COORD_MIN[tgr_pkg::COORD_W-1:0];
    return v[tgr_pkg::COORD_W-1:0];
  endfunction

  function automatic void apply_reg(input logic [tgr_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [tgr_pkg::CFG_DATA_W-1:0] value);
    case (idx)
      tgr_pkg::REG_START_X: begin
        start_x_r = $signed(value[tgr_pkg::COORD_W-1:0]);
      end
      tgr_pkg::REG_START_Y: begin
        start_y_r = $signed(value[tgr_pkg::COORD_W-1:0]);
      end
      tgr_pkg::REG_DOT_SIZE: begin
        size_r = value[tgr_pkg::SIZE_W-1:0];
      end
      tgr_pkg::REG_DRAW_COLOR: begin
        color_r = value[tgr_pkg::COLOR_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Works out the squares one character draws and moves the cursor on. With keep
  // clear only the cursor is updated, for rows whose squares are typed in.
  task automatic rasterize_char(input tgr_pkg::in_t req, input bit keep);
    int            glyph;
    int            ps;
    logic [7:0]    key;
    tgr_pkg::out_t sq;
    tgr_pkg::out_t run [$];
    ps = int'(size_r);
    if (req.first_of_text) cursor_r = start_x_r;
    if (ps == 0) return;
    key = req.char_code;
    if (key >= tgr_pkg::CHAR_LOWER_A && key <= tgr_pkg::CHAR_LOWER_Z) begin
      key = key - tgr_pkg::CASE_FOLD;
    end
    glyph = -1;
    for (int i = 0; i < tgr_pkg::GLYPH_COUNT; i++) begin
      if (tgr_pkg::GLYPH_CODES[i] == key) glyph = i;
    end
    if (glyph >= 0) begin
      // Row-major scan from the top left; the leftmost pixel is the row's MSB.
      for (int r = 0; r < tgr_pkg::GLYPH_ROWS; r++) begin
        for (int c = 0; c < tgr_pkg::GLYPH_COLS; c++) begin
          if (tgr_pkg::GLYPH_ROM[glyph][r][tgr_pkg::GLYPH_COLS-1-c]) begin
            sq.square_x     = clamp_coord(cursor_r + c * ps);
            sq.square_y     = clamp_coord(start_y_r + r * ps);
            sq.square_size  = size_r;
            sq.square_color = color_r;
            sq.last_square  = 1'b0;
            run.push_back(sq);
          end
        end
      end
      if (run.size() > 0) run[run.size()-1].last_square = 1'b1;
    end
    // Blank glyphs still take up a character cell.
    cursor_r = clamp_coord(cursor_r + tgr_pkg::CELL_COLS * ps);
    if (keep) begin
      foreach (run[k]) pending_squares.push_back(run[k]);
    end
  endtask

  task automatic expect_run(input plan_row_t row);
    tgr_pkg::out_t sq;
    for (int k = 0; k < row.n; k++) begin
      sq.square_x     = 16'(row.x0 + k * row.dx);
      sq.square_y     = 16'(row.y0 + k * row.dy);
      sq.square_size  = row.size;
      sq.square_color = row.color;
      sq.last_square  = (k == row.n - 1);
      pending_squares.push_back(sq);
    end
  endtask

  // Offers one character request and returns at the edge that accepts it. The
  // valid line is left high, so a following request goes out back to back
  // unless a random idle cycle lowers it first.
  task automatic send_char(input tgr_pkg::in_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Brings the block to idle: no request offered, every predicted square seen,
  // and time for a trailing character that draws nothing to finish.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_squares.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tgr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tgr_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_reg(idx, value);
    @(posedge clk);
  endtask

  // Mostly real glyphs, then lower-case letters, then any byte at all.
  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return tgr_pkg::GLYPH_CODES[$urandom_range(0, tgr_pkg::GLYPH_COUNT - 1)];
    if (r < 75) return 8'($urandom_range(tgr_pkg::CHAR_LOWER_A, tgr_pkg::CHAR_LOWER_Z));
    return 8'($urandom_range(0, 255));
  endfunction

  // Picks a new register setting, with the extremes of each range well represented.
  task automatic program_random_setting();
    logic [tgr_pkg::CFG_DATA_W-1:0] value;
    value = $urandom;
    case ($urandom_range(0, 3))
      0: value[tgr_pkg::COORD_W-1:0] = 16'h8000;
      1: value[tgr_pkg::COORD_W-1:0] = 16'h7FFF;
      default: begin
      end
    endcase
    write_reg(tgr_pkg::REG_START_X, value);
    value = $urandom;
    case ($urandom_range(0, 3))
      0: value[tgr_pkg::COORD_W-1:0] = 16'h8000;
      1: value[tgr_pkg::COORD_W-1:0] = 16'h7FFF;
      default: begin
      end
    endcase
    write_reg(tgr_pkg::REG_START_Y, value);
    value = $urandom;
    case ($urandom_range(0, 9))
      0: value[tgr_pkg::SIZE_W-1:0] = 8'd0;
      1: value[tgr_pkg::SIZE_W-1:0] = 8'd255;
      2: value[tgr_pkg::SIZE_W-1:0] = 8'd1;
      default: value[tgr_pkg::SIZE_W-1:0] = 8'($urandom_range(1, 12));
    endcase
    write_reg(tgr_pkg::REG_DOT_SIZE, value);
    case ($urandom_range(0, 5))
      0: value = 32'h0000_0000;
      1: value = 32'hFFFF_FFFF;
      default: value = $urandom;
    endcase
    write_reg(tgr_pkg::REG_DRAW_COLOR, value);
    // Now and then a write to an index the block does not decode.
    if ($urandom_range(0, 3) == 0) write_reg(8'($urandom_range(4, 255)), $urandom);
  endtask

  // Receiver side: random stalls at the current rate, or a long hold-off when
  // the main sequence asks for one, so the block fills up and stalls its input.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Every square request the block hands over is matched against the oldest
  // prediction. Values read here are the ones present before the edge.
  always @(posedge clk) begin : check_squares
    tgr_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_squares.size() == 0) begin
        $error("square request with none expected: x=%0d y=%0d", out_data.square_x,
               out_data.square_y);
        errors++;
      end else begin
        want = pending_squares.pop_front();
        if (out_data.square_x !== want.square_x) begin
          $error("square_x expected %0d actual %0d", want.square_x, out_data.square_x);
          errors++;
        end
        if (out_data.square_y !== want.square_y) begin
          $error("square_y expected %0d actual %0d", want.square_y, out_data.square_y);
          errors++;
        end
        if (out_data.square_size !== want.square_size) begin
          $error("square_size expected %0d actual %0d", want.square_size,
                 out_data.square_size);
          errors++;
        end
        if (out_data.square_color !== want.square_color) begin
          $error("square_color expected %h actual %h", want.square_color,
                 out_data.square_color);
          errors++;
        end
        if (out_data.last_square !== want.last_square) begin
          $error("last_square expected %0b actual %0b", want.last_square,
                 out_data.last_square);
          errors++;
        end
      end
    end
  end

  initial begin : main_sequence
    tgr_pkg::in_t req;
    int           count;
    int           word_left;
    start_x_r = tgr_pkg::START_X_RESET;
    start_y_r = tgr_pkg::START_Y_RESET;
    size_r    = tgr_pkg::DOT_SIZE_RESET;
    color_r   = tgr_pkg::DRAW_COLOR_RESET;
    cursor_r  = 0;
    word_left = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, run with the first idling pattern.
    send_idle_pct = 23;
    recv_idle_pct = 72;
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].kind == ROW_REG) begin
        drain_block();
        write_reg(PLAN[i].idx, PLAN[i].data);
      end else begin
        req.char_code     = PLAN[i].code;
        req.first_of_text = PLAN[i].first;
        rasterize_char(req, !PLAN[i].typed);
        if (PLAN[i].typed) expect_run(PLAN[i]);
        send_char(req);
      end
    end

    // Random text: three idling patterns, several register settings each.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int setting = 0; setting < 4; setting++) begin
        drain_block();
        program_random_setting();
        // With no idling at all, the receiver backs off for a long stretch while
        // characters keep coming, so the input stall is exercised. The hold-off
        // only backs the block up when characters draw squares.
        if (mode == 2 && setting == 0) begin
          if (size_r == '0) write_reg(tgr_pkg::REG_DOT_SIZE, 32'd3);
          hold_request = 1'b1;
        end
        count = $urandom_range(24, 34);
        for (int k = 0; k < count; k++) begin
          // Words of a few characters, the first one reloading the cursor, with
          // a stray reload now and then.
          if (word_left == 0) begin
            word_left         = $urandom_range(1, 8);
            req.first_of_text = 1'b1;
          end else begin
            req.first_of_text = ($urandom_range(0, 9) == 0);
          end
          word_left     = word_left - 1;
          req.char_code = pick_code();
          rasterize_char(req, 1'b1);
          send_char(req);
        end
      end
    end

    drain_block();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
